// ===== design/letterbox_bilinear_scaler_defines.svh =====
// Assertion macros shared by the checker of the letterbox scaler.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef LETTERBOX_BILINEAR_SCALER_DEFINES_SVH
`define LETTERBOX_BILINEAR_SCALER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define LBS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/lbs_pkg.sv =====
// Package of the letterbox scaler: sizes, derived widths, codes and types.
// Used by the interfaces, the geometry unit and the top level.
`timescale 1ns / 1ps

package lbs_pkg;

  localparam int MAX_SRC_WIDTH  = 512;
  localparam int MAX_SRC_HEIGHT = 512;
  localparam int MAX_DST_SIZE   = 1024;
  localparam int FRAC_BITS      = 16;

  localparam int POS_W      = 10;
  localparam int SRC_SZ_W   = 10;
  localparam int DST_SZ_W   = 11;
  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 11;

  localparam int RST_SRC_SIZE = 512;
  localparam int RST_DST_SIZE = 640;

  localparam int XW      = $clog2(MAX_SRC_WIDTH);
  localparam int YW      = $clog2(MAX_SRC_HEIGHT);
  localparam int SMW     = (XW > YW) ? XW : YW;
  localparam int RW      = SMW + FRAC_BITS;
  localparam int PW      = POS_W + RW;
  localparam int IW      = PW - FRAC_BITS;
  localparam int PRW     = DST_SZ_W + SRC_SZ_W;
  localparam int DN_U    = PRW + 2;
  localparam int DN      = (RW > DN_U) ? RW : DN_U;
  localparam int DD      = ((SRC_SZ_W + 1) > DST_SZ_W) ? SRC_SZ_W + 1 : DST_SZ_W;
  localparam int CNT_W   = $clog2(DN);
  localparam int BANK_AW = (XW - 1) + (YW - 1);
  localparam int BANK_DEPTH = 1 << BANK_AW;
  localparam int HW      = CH_W + FRAC_BITS;
  localparam int VW      = HW + FRAC_BITS;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SRC_W = 3'd0,
    REG_SRC_H = 3'd1,
    REG_DST_W = 3'd2,
    REG_DST_H = 3'd3,
    REG_PAD0  = 3'd4,
    REG_PAD1  = 3'd5,
    REG_PAD2  = 3'd6
  } cfg_reg_t;

  typedef enum logic [3:0] {
    G_PROD,
    G_LDU,
    G_DIV_U,
    G_LDX,
    G_DIV_X,
    G_LDY,
    G_DIV_Y,
    G_EDGE,
    G_IDLE
  } geom_state_t;

  typedef struct packed {
    logic [DST_SZ_W-1:0] left;
    logic [DST_SZ_W-1:0] right;
    logic [DST_SZ_W-1:0] top;
    logic [DST_SZ_W-1:0] bottom;
    logic [RW-1:0]       rx;
    logic [RW-1:0]       ry;
    logic [XW-1:0]       sw_m1;
    logic [YW-1:0]       sh_m1;
  } geom_t;

endpackage

// ===== design/lbs_ifs.sv =====
// Valid/ready channel interfaces of the letterbox scaler: requests in, results out.
// Depends on lbs_pkg for the field widths.
`timescale 1ns / 1ps

interface lbs_in_if;
  import lbs_pkg::*;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [POS_W-1:0]  col;
  logic [POS_W-1:0]  row;
  logic [CH_W-1:0]   in_ch0;
  logic [CH_W-1:0]   in_ch1;
  logic [CH_W-1:0]   in_ch2;
  modport source (output valid, kind, col, row, in_ch0, in_ch1, in_ch2, input ready);
  modport sink   (input valid, kind, col, row, in_ch0, in_ch1, in_ch2, output ready);
endinterface

interface lbs_out_if;
  import lbs_pkg::*;
  logic              valid;
  logic              ready;
  logic [CH_W-1:0]   out_ch0;
  logic [CH_W-1:0]   out_ch1;
  logic [CH_W-1:0]   out_ch2;
  logic              in_border;
  modport source (output valid, out_ch0, out_ch1, out_ch2, in_border, input ready);
  modport sink   (input valid, out_ch0, out_ch1, out_ch2, in_border, output ready);
endinterface

// ===== design/lbs_geom.sv =====
// Geometry unit: unpadded size, pads and Q-format step ratios from the size registers.
// Uses one shared restoring divider; depends on lbs_pkg.
`timescale 1ns / 1ps

module lbs_geom (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [lbs_pkg::SRC_SZ_W-1:0]  src_width,
  input  logic [lbs_pkg::SRC_SZ_W-1:0]  src_height,
  input  logic [lbs_pkg::DST_SZ_W-1:0]  dst_width,
  input  logic [lbs_pkg::DST_SZ_W-1:0]  dst_height,
  output lbs_pkg::geom_t                geom,
  output logic                          busy
);
  import lbs_pkg::*;

  geom_state_t state_r, state_nxt;

  logic [SRC_SZ_W-1:0] sw_c, sh_c, sw_r, sh_r;
  logic [DST_SZ_W-1:0] dw_c, dh_c, dw_r, dh_r, uw_r, uh_r;
  logic [PRW-1:0]      pw_r, ph_r;
  logic                fit_r;
  logic [DN-1:0]       div_num_r;
  logic [DD-1:0]       div_rem_r, div_den_r;
  logic [CNT_W-1:0]    cnt_r;
  geom_t               geom_r;

  logic [DD:0]         dv_sh;
  logic [DD-1:0]       dv_rem;
  logic                dv_bit;
  logic [DST_SZ_W-1:0] q_c, uw_new, uh_new, left_c, top_c;
  logic [DD-1:0]       den_x, den_y;
  logic [XW-1:0]       sw_m1_c;
  logic [YW-1:0]       sh_m1_c;
  logic                fit_c;

  // Sizes saturated to their legal ranges.
  always_comb begin
    if (src_width == '0) begin
      sw_c = SRC_SZ_W'(1);
    end else if (32'(src_width) > MAX_SRC_WIDTH) begin
      sw_c = SRC_SZ_W'(MAX_SRC_WIDTH);
    end else begin
      sw_c = src_width;
    end
    if (src_height == '0) begin
      sh_c = SRC_SZ_W'(1);
    end else if (32'(src_height) > MAX_SRC_HEIGHT) begin
      sh_c = SRC_SZ_W'(MAX_SRC_HEIGHT);
    end else begin
      sh_c = src_height;
    end
    if (dst_width == '0) begin
      dw_c = DST_SZ_W'(1);
    end else if (32'(dst_width) > MAX_DST_SIZE) begin
      dw_c = DST_SZ_W'(MAX_DST_SIZE);
    end else begin
      dw_c = dst_width;
    end
    if (dst_height == '0) begin
      dh_c = DST_SZ_W'(1);
    end else if (32'(dst_height) > MAX_DST_SIZE) begin
      dh_c = DST_SZ_W'(MAX_DST_SIZE);
    end else begin
      dh_c = dst_height;
    end
  end

  // One quotient bit per cycle.
  always_comb begin
    dv_sh = {div_rem_r, div_num_r[DN-1]};
    if (dv_sh >= {1'b0, div_den_r}) begin
      dv_rem = DD'(dv_sh - {1'b0, div_den_r});
      dv_bit = 1'b1;
    end else begin
      dv_rem = dv_sh[DD-1:0];
      dv_bit = 1'b0;
    end
  end

  always_comb begin
    fit_c   = (pw_r <= ph_r);
    q_c     = div_num_r[DST_SZ_W-1:0];
    uw_new  = fit_r ? dw_r : q_c;
    uh_new  = fit_r ? q_c : dh_r;
    den_x   = (uw_new > DST_SZ_W'(1)) ? DD'(uw_new - 1'b1) : DD'(1);
    den_y   = (uh_r > DST_SZ_W'(1)) ? DD'(uh_r - 1'b1) : DD'(1);
    sw_m1_c = XW'(sw_r - 1'b1);
    sh_m1_c = YW'(sh_r - 1'b1);
    left_c  = DST_SZ_W'((dw_r - uw_r) >> 1);
    top_c   = DST_SZ_W'((dh_r - uh_r) >> 1);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      G_PROD:  state_nxt = G_LDU;
      G_LDU:   state_nxt = G_DIV_U;
      G_DIV_U: if (cnt_r == CNT_W'(DN - 1)) state_nxt = G_LDX;
      G_LDX:   state_nxt = G_DIV_X;
      G_DIV_X: if (cnt_r == CNT_W'(DN - 1)) state_nxt = G_LDY;
      G_LDY:   state_nxt = G_DIV_Y;
      G_DIV_Y: if (cnt_r == CNT_W'(DN - 1)) state_nxt = G_EDGE;
      G_EDGE:  state_nxt = G_IDLE;
      G_IDLE:  state_nxt = G_IDLE;
      default: state_nxt = G_IDLE;
    endcase
    if (cfg_we) begin
      state_nxt = G_PROD;
    end
  end

  // Outputs.
  always_comb begin
    busy = (state_r != G_IDLE);
    geom = geom_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= G_PROD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      G_PROD: begin
        sw_r <= sw_c;
        sh_r <= sh_c;
        dw_r <= dw_c;
        dh_r <= dh_c;
        pw_r <= PRW'(dw_c) * PRW'(sh_c);
        ph_r <= PRW'(dh_c) * PRW'(sw_c);
      end
      G_LDU: begin
        fit_r     <= fit_c;
        div_num_r <= fit_c ? DN'({pw_r, 1'b0}) + DN'(sw_r) : DN'({ph_r, 1'b0}) + DN'(sh_r);
        div_den_r <= fit_c ? DD'({sw_r, 1'b0}) : DD'({sh_r, 1'b0});
        div_rem_r <= '0;
        cnt_r     <= '0;
      end
      G_DIV_U, G_DIV_X, G_DIV_Y: begin
        div_num_r <= {div_num_r[DN-2:0], dv_bit};
        div_rem_r <= dv_rem;
        cnt_r     <= cnt_r + 1'b1;
      end
      G_LDX: begin
        uw_r      <= uw_new;
        uh_r      <= uh_new;
        div_num_r <= DN'({sw_m1_c, {FRAC_BITS{1'b0}}});
        div_den_r <= den_x;
        div_rem_r <= '0;
        cnt_r     <= '0;
      end
      G_LDY: begin
        geom_r.rx <= div_num_r[RW-1:0];
        div_num_r <= DN'({sh_m1_c, {FRAC_BITS{1'b0}}});
        div_den_r <= den_y;
        div_rem_r <= '0;
        cnt_r     <= '0;
      end
      G_EDGE: begin
        geom_r.ry     <= div_num_r[RW-1:0];
        geom_r.left   <= left_c;
        geom_r.right  <= DST_SZ_W'(left_c + uw_r);
        geom_r.top    <= top_c;
        geom_r.bottom <= DST_SZ_W'(top_c + uh_r);
        geom_r.sw_m1  <= sw_m1_c;
        geom_r.sh_m1  <= sh_m1_c;
      end
      default: ;
    endcase
  end

endmodule

// ===== design/letterbox_bilinear_scaler.sv =====
// Letterbox bilinear scaler for three-channel 8-bit images. A load request (kind 0) writes one
// source pixel into the frame store, a query request (kind 1) returns one pixel of the
// letterboxed output: the pad colour with in_border set in the border, otherwise a truncated
// bilinear blend of four source pixels. The datapath is a six-stage pipeline that takes one
// request per clock unless out_px.ready, the geometry update or a register write stalls it;
// loads give no result. One request per clock is possible because the frame store is split
// into four banks by row and column parity, so the four neighbours of a query are read in the
// same cycle, one per bank. The geometry (pads, unpadded size, step ratios) is worked out by a
// shared one-bit-per-cycle divider after reset and after every configuration write; in_px.ready
// is low while it runs. Configuration must only be written while the pipeline is empty. The
// frame store has no reset; a query that reads a never-written pixel returns undefined data.
// Depends on lbs_pkg, the channel interfaces and lbs_geom.
`timescale 1ns / 1ps

module letterbox_bilinear_scaler (
  input  logic                            clk,
  input  logic                            rst_n,
  lbs_in_if.sink                          in_px,
  lbs_out_if.source                       out_px,
  input  logic                            cfg_we,
  input  logic [lbs_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [lbs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import lbs_pkg::*;

  // Configuration registers.
  logic [SRC_SZ_W-1:0] src_width_r, src_height_r;
  logic [DST_SZ_W-1:0] dst_width_r, dst_height_r;
  logic [CH_W-1:0]     pad_ch0_r, pad_ch1_r, pad_ch2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= SRC_SZ_W'(RST_SRC_SIZE);
      src_height_r <= SRC_SZ_W'(RST_SRC_SIZE);
      dst_width_r  <= DST_SZ_W'(RST_DST_SIZE);
      dst_height_r <= DST_SZ_W'(RST_DST_SIZE);
      pad_ch0_r    <= '0;
      pad_ch1_r    <= '0;
      pad_ch2_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_SRC_W: src_width_r  <= cfg_wdata[SRC_SZ_W-1:0];
        REG_SRC_H: src_height_r <= cfg_wdata[SRC_SZ_W-1:0];
        REG_DST_W: dst_width_r  <= cfg_wdata[DST_SZ_W-1:0];
        REG_DST_H: dst_height_r <= cfg_wdata[DST_SZ_W-1:0];
        REG_PAD0:  pad_ch0_r    <= cfg_wdata[CH_W-1:0];
        REG_PAD1:  pad_ch1_r    <= cfg_wdata[CH_W-1:0];
        REG_PAD2:  pad_ch2_r    <= cfg_wdata[CH_W-1:0];
        default: ;
      endcase
    end
  end

  // Geometry, stable whenever requests are accepted.
  geom_t geom;
  logic  geom_busy;

  lbs_geom u_geom (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .src_width  (src_width_r),
    .src_height (src_height_r),
    .dst_width  (dst_width_r),
    .dst_height (dst_height_r),
    .geom       (geom),
    .busy       (geom_busy)
  );

  // Pipeline flow control: a stage takes new data when it is empty or its successor moves.
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic en1, en2, en3, en4, en5, en6, acc;
  logic kind1_r, kind2_r, kind3_r;

  always_comb begin
    en6 = !v6_r || out_px.ready;
    en5 = !v5_r || en6;
    en4 = !v4_r || en5;
    en3 = !v3_r || en4;
    en2 = !v2_r || en3;
    en1 = !v1_r || en2;
    in_px.ready = en1 && !geom_busy && !cfg_we;
    acc = in_px.valid && in_px.ready;
  end

  // Loads leave the pipeline once they have written the store.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (en1) v1_r <= acc;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r && (kind3_r == KIND_QUERY);
      if (en5) v5_r <= v4_r;
      if (en6) v6_r <= v5_r;
    end
  end

  // Stage 1: request registered.
  logic [POS_W-1:0] col1_r, row1_r, col2_r, row2_r, col3_r, row3_r;
  logic [PIX_W-1:0] pix1_r, pix2_r, pix3_r;

  always_ff @(posedge clk) begin
    if (en1) begin
      kind1_r <= in_px.kind;
      col1_r  <= in_px.col;
      row1_r  <= in_px.row;
      pix1_r  <= {in_px.in_ch2, in_px.in_ch1, in_px.in_ch0};
    end
  end

  // Stage 2: border test and offsets into the unpadded image.
  logic             border1, border2_r, border3_r, border4_r, border5_r, border6_r;
  logic [POS_W-1:0] ox1, oy1, ox2_r, oy2_r;

  always_comb begin
    border1 = !((DST_SZ_W'(col1_r) >= geom.left) && (DST_SZ_W'(col1_r) < geom.right) &&
                (DST_SZ_W'(row1_r) >= geom.top)  && (DST_SZ_W'(row1_r) < geom.bottom));
    ox1 = POS_W'(DST_SZ_W'(col1_r) - geom.left);
    oy1 = POS_W'(DST_SZ_W'(row1_r) - geom.top);
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      kind2_r   <= kind1_r;
      col2_r    <= col1_r;
      row2_r    <= row1_r;
      pix2_r    <= pix1_r;
      border2_r <= border1;
      ox2_r     <= ox1;
      oy2_r     <= oy1;
    end
  end

  // Stage 3: source position in fixed point.
  logic [PW-1:0] px3_r, py3_r;

  always_ff @(posedge clk) begin
    if (en3) begin
      kind3_r   <= kind2_r;
      col3_r    <= col2_r;
      row3_r    <= row2_r;
      pix3_r    <= pix2_r;
      border3_r <= border2_r;
      px3_r     <= PW'(ox2_r) * PW'(geom.rx);
      py3_r     <= PW'(oy2_r) * PW'(geom.ry);
    end
  end

  // Stage 4: neighbour coordinates, store write for loads and banked store read for queries.
  logic [XW-1:0]        x1, x2;
  logic [YW-1:0]        y1, y2;
  logic [IW-1:0]        x_int, y_int;
  logic                 wr_en;
  logic [1:0]           wr_bank;
  logic [BANK_AW-1:0]   wr_addr;

  always_comb begin
    x_int = px3_r[PW-1:FRAC_BITS];
    y_int = py3_r[PW-1:FRAC_BITS];
    x1 = (x_int > IW'(geom.sw_m1)) ? geom.sw_m1 : x_int[XW-1:0];
    y1 = (y_int > IW'(geom.sh_m1)) ? geom.sh_m1 : y_int[YW-1:0];
    x2 = (x1 < geom.sw_m1) ? XW'(x1 + 1'b1) : geom.sw_m1;
    y2 = (y1 < geom.sh_m1) ? YW'(y1 + 1'b1) : geom.sh_m1;
    wr_en   = en4 && v3_r && (kind3_r == KIND_LOAD) &&
              (32'(col3_r) < MAX_SRC_WIDTH) && (32'(row3_r) < MAX_SRC_HEIGHT);
    wr_bank = {row3_r[0], col3_r[0]};
    wr_addr = {row3_r[YW-1:1], col3_r[XW-1:1]};
  end

  logic [PIX_W-1:0]     rd4_r [4];
  logic [FRAC_BITS-1:0] fx4_r, fy4_r, fy5_r;
  logic                 x1p4_r, x2p4_r, y1p4_r, y2p4_r;

  // Bank index is {row parity, column parity}. Each bank reads whichever neighbour falls in it.
  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [PIX_W-1:0]   mem [BANK_DEPTH];
    logic [XW-1:0]      cx;
    logic [YW-1:0]      cy;
    logic [BANK_AW-1:0] raddr;

    always_comb begin
      cx    = (x1[0] == 1'(b % 2)) ? x1 : x2;
      cy    = (y1[0] == 1'(b / 2)) ? y1 : y2;
      raddr = {cy[YW-1:1], cx[XW-1:1]};
    end

    always_ff @(posedge clk) begin
      if (wr_en && (wr_bank == 2'(b))) begin
        mem[wr_addr] <= pix3_r;
      end
      if (en4) begin
        rd4_r[b] <= mem[raddr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      border4_r <= border3_r;
      fx4_r     <= px3_r[FRAC_BITS-1:0];
      fy4_r     <= py3_r[FRAC_BITS-1:0];
      x1p4_r    <= x1[0];
      x2p4_r    <= x2[0];
      y1p4_r    <= y1[0];
      y2p4_r    <= y2[0];
    end
  end

  // Stage 5: horizontal blends, kept exact.
  logic [PIX_W-1:0]   wa, wb, wc, wd;
  logic [HW-1:0]      up4 [3];
  logic [HW-1:0]      lo4 [3];
  logic [HW-1:0]      up5_r [3];
  logic [HW-1:0]      lo5_r [3];
  logic [FRAC_BITS:0] fx_inv;

  always_comb begin
    wa = rd4_r[{y1p4_r, x1p4_r}];
    wb = rd4_r[{y1p4_r, x2p4_r}];
    wc = rd4_r[{y2p4_r, x1p4_r}];
    wd = rd4_r[{y2p4_r, x2p4_r}];
    fx_inv = (FRAC_BITS+1)'(1 << FRAC_BITS) - (FRAC_BITS+1)'(fx4_r);
    for (int c = 0; c < 3; c++) begin
      up4[c] = HW'(wa[c*CH_W +: CH_W]) * HW'(fx_inv) + HW'(wb[c*CH_W +: CH_W]) * HW'(fx4_r);
      lo4[c] = HW'(wc[c*CH_W +: CH_W]) * HW'(fx_inv) + HW'(wd[c*CH_W +: CH_W]) * HW'(fx4_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      border5_r <= border4_r;
      fy5_r     <= fy4_r;
      for (int c = 0; c < 3; c++) begin
        up5_r[c] <= up4[c];
        lo5_r[c] <= lo4[c];
      end
    end
  end

  // Stage 6: vertical blend, truncation and border colour; this is the output register.
  logic [VW-1:0]      vb5 [3];
  logic [FRAC_BITS:0] fy_inv;
  logic [CH_W-1:0]    ch6_r [3];

  always_comb begin
    fy_inv = (FRAC_BITS+1)'(1 << FRAC_BITS) - (FRAC_BITS+1)'(fy5_r);
    for (int c = 0; c < 3; c++) begin
      vb5[c] = VW'(up5_r[c]) * VW'(fy_inv) + VW'(lo5_r[c]) * VW'(fy5_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      border6_r <= border5_r;
      ch6_r[0]  <= border5_r ? pad_ch0_r : vb5[0][2*FRAC_BITS +: CH_W];
      ch6_r[1]  <= border5_r ? pad_ch1_r : vb5[1][2*FRAC_BITS +: CH_W];
      ch6_r[2]  <= border5_r ? pad_ch2_r : vb5[2][2*FRAC_BITS +: CH_W];
    end
  end

  assign out_px.valid     = v6_r;
  assign out_px.out_ch0   = ch6_r[0];
  assign out_px.out_ch1   = ch6_r[1];
  assign out_px.out_ch2   = ch6_r[2];
  assign out_px.in_border = border6_r;

endmodule

// ===== design/lbs_checker.sv =====
// Port-level checker of the letterbox scaler and the bind that attaches it.
// Depends on letterbox_bilinear_scaler_defines.svh for the assertion macros.
`timescale 1ns / 1ps
`include "letterbox_bilinear_scaler_defines.svh"

module lbs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_ch0,
  input logic [7:0] out_ch1,
  input logic [7:0] out_ch2,
  input logic       out_border,
  input logic       cfg_we
);

  `LBS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `LBS_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_ch0) && $stable(out_ch1) && $stable(out_ch2) && $stable(out_border), "stalled result changed")
  `LBS_ASSERT_NOW(a_cfg_block, cfg_we, !in_ready, "request accepted during a register write")
  `LBS_ASSERT_NEXT(a_geom_busy, cfg_we, !in_ready, "request accepted before geometry update")

endmodule

bind letterbox_bilinear_scaler lbs_checker u_lbs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_px.valid),
  .in_ready   (in_px.ready),
  .out_valid  (out_px.valid),
  .out_ready  (out_px.ready),
  .out_ch0    (out_px.out_ch0),
  .out_ch1    (out_px.out_ch1),
  .out_ch2    (out_px.out_ch2),
  .out_border (out_px.in_border),
  .cfg_we     (cfg_we)
);

// ===== dv/tb.sv =====
// Self-checking testbench for the letterbox bilinear scaler: loads, queries and register writes.
// Depends on lbs_pkg, the channel interfaces in lbs_ifs.sv and the scaler RTL.
`timescale 1ns / 1ps

module tb;
  import lbs_pkg::*;

  // Register index that no register answers to; writes to it must change nothing.
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;
  // Cycles to let the pipeline empty of loads before a register write.
  localparam int PIPE_SETTLE = 12;
  // Length of the long receiver hold-off.
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [CH_W-1:0] ch0;
    logic [CH_W-1:0] ch1;
    logic [CH_W-1:0] ch2;
    logic            border;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  lbs_in_if  in_px ();
  lbs_out_if out_px ();

  letterbox_bilinear_scaler dut (
    .clk(clk), .rst_n(rst_n), .in_px(in_px), .out_px(out_px),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  // Our own copy of the registers and of the frame store. Only written entries exist.
  int unsigned reg_src_w = RST_SRC_SIZE, reg_src_h = RST_SRC_SIZE;
  int unsigned reg_dst_w = RST_DST_SIZE, reg_dst_h = RST_DST_SIZE;
  int unsigned reg_pad0 = 0, reg_pad1 = 0, reg_pad2 = 0;
  logic [PIX_W-1:0] frame_store [int unsigned];

  pixel_t pending_pixels [$];
  int  errors = 0;
  bit  send_steady = 1'b0;   // sender offers requests back to back
  bit  recv_steady = 1'b0;   // receiver never idles
  int  hold_requests = 0;    // raised by a test to ask for a long hold-off
  int  hold_taken = 0;       // hold-off requests the receiver has started
  int  hold_off = 0;         // cycles the receiver still refuses results

  function automatic longint unsigned sat(input int unsigned v, input int unsigned hi);
    return (v < 1) ? 1 : (v > hi) ? hi : v;
  endfunction

  // Works out the letterboxed pixel at (col,row). Returns 1 when it is an image pixel, and then
  // nb holds the store addresses of its four neighbours; the blend is taken from what is stored.
  function automatic bit scale_pixel(input int unsigned col, input int unsigned row,
                                     output pixel_t px, output int unsigned nb[4]);
    longint unsigned sw, sh, dw, dh, uw, uh, left, top, rx, ry, pxp, pyp;
    longint unsigned x1, y1, x2, y2, fx, fy, one, up, lo, v;
    logic [PIX_W-1:0] w [4];
    logic [CH_W-1:0]  res [3];
    one = 64'd1 << FRAC_BITS;
    sw = sat(reg_src_w, MAX_SRC_WIDTH);
    sh = sat(reg_src_h, MAX_SRC_HEIGHT);
    dw = sat(reg_dst_w, MAX_DST_SIZE);
    dh = sat(reg_dst_h, MAX_DST_SIZE);
    // The smaller ratio wins; the other axis is rounded half up.
    if (dw * sh <= dh * sw) begin
      uw = dw;
      uh = (2 * sh * dw + sw) / (2 * sw);
    end else begin
      uh = dh;
      uw = (2 * sw * dh + sh) / (2 * sh);
    end
    left = (dw - uw) / 2;
    top  = (dh - uh) / 2;
    px = '{ch0: CH_W'(reg_pad0), ch1: CH_W'(reg_pad1), ch2: CH_W'(reg_pad2), border: 1'b1};
    nb = '{0, 0, 0, 0};
    if (col >= dw || row >= dh || uw == 0 || uh == 0 ||
        col < left || col >= left + uw || row < top || row >= top + uh)
      return 1'b0;
    rx = ((sw - 1) << FRAC_BITS) / ((uw > 1) ? uw - 1 : 1);
    ry = ((sh - 1) << FRAC_BITS) / ((uh > 1) ? uh - 1 : 1);
    pxp = (col - left) * rx;
    pyp = (row - top) * ry;
    x1 = pxp >> FRAC_BITS;
    y1 = pyp >> FRAC_BITS;
    fx = pxp & (one - 1);
    fy = pyp & (one - 1);
    if (x1 > sw - 1) x1 = sw - 1;
    if (y1 > sh - 1) y1 = sh - 1;
    x2 = (x1 + 1 < sw) ? x1 + 1 : sw - 1;
    y2 = (y1 + 1 < sh) ? y1 + 1 : sh - 1;
    nb[0] = 32'(y1 * MAX_SRC_WIDTH + x1);
    nb[1] = 32'(y1 * MAX_SRC_WIDTH + x2);
    nb[2] = 32'(y2 * MAX_SRC_WIDTH + x1);
    nb[3] = 32'(y2 * MAX_SRC_WIDTH + x2);
    foreach (w[i]) w[i] = frame_store.exists(nb[i]) ? frame_store[nb[i]] : '0;
    foreach (res[c]) begin
      up = w[0][c*CH_W +: CH_W] * (one - fx) + w[1][c*CH_W +: CH_W] * fx;
      lo = w[2][c*CH_W +: CH_W] * (one - fx) + w[3][c*CH_W +: CH_W] * fx;
      v  = up * (one - fy) + lo * fy;
      res[c] = CH_W'(v >> (2 * FRAC_BITS));
    end
    px = '{ch0: res[0], ch1: res[1], ch2: res[2], border: 1'b0};
    return 1'b1;
  endfunction

  // Offers one request and waits for it to be taken; then applies it to our copy of the block.
  task automatic send_request(input logic kind, input int unsigned col, input int unsigned row,
                              input logic [PIX_W-1:0] data);
    pixel_t px;
    int unsigned nb[4];
    bit in_image;
    if (!send_steady && $urandom_range(99) < 11) begin
      in_px.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    in_px.valid  <= 1'b1;
    in_px.kind   <= kind;
    in_px.col    <= col[POS_W-1:0];
    in_px.row    <= row[POS_W-1:0];
    in_px.in_ch0 <= data[7:0];
    in_px.in_ch1 <= data[15:8];
    in_px.in_ch2 <= data[23:16];
    do @(posedge clk); while (!in_px.ready);
    if (kind == KIND_LOAD) begin
      if (col < MAX_SRC_WIDTH && row < MAX_SRC_HEIGHT)
        frame_store[row * MAX_SRC_WIDTH + col] = data;
    end else begin
      in_image = scale_pixel(col, row, px, nb);
      pending_pixels.push_back(px);
    end
    @(negedge clk);
  endtask

  // A query whose neighbours have not all been written is preceded by loads that fill them in.
  task automatic query_pixel(input int unsigned col, input int unsigned row);
    pixel_t px;
    int unsigned nb[4];
    if (scale_pixel(col, row, px, nb))
      foreach (nb[i])
        if (!frame_store.exists(nb[i]))
          send_request(KIND_LOAD, nb[i] % MAX_SRC_WIDTH, nb[i] / MAX_SRC_WIDTH,
                       PIX_W'($urandom));
    send_request(KIND_QUERY, col, row, PIX_W'($urandom));
  endtask

  task automatic wait_idle();
    in_px.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  // Register writes happen only with the pipeline empty.
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input int unsigned val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    case (idx)
      REG_SRC_W: reg_src_w = val & 10'h3ff;
      REG_SRC_H: reg_src_h = val & 10'h3ff;
      REG_DST_W: reg_dst_w = val & 11'h7ff;
      REG_DST_H: reg_dst_h = val & 11'h7ff;
      REG_PAD0:  reg_pad0  = val & 8'hff;
      REG_PAD1:  reg_pad1  = val & 8'hff;
      REG_PAD2:  reg_pad2  = val & 8'hff;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_geometry(input int unsigned sw, input int unsigned sh,
                              input int unsigned dw, input int unsigned dh);
    wait_idle();
    write_reg(REG_SRC_W, sw);
    write_reg(REG_SRC_H, sh);
    write_reg(REG_DST_W, dw);
    write_reg(REG_DST_H, dh);
  endtask

  task automatic set_pad(input int unsigned p0, input int unsigned p1, input int unsigned p2);
    wait_idle();
    write_reg(REG_PAD0, p0);
    write_reg(REG_PAD1, p1);
    write_reg(REG_PAD2, p2);
  endtask

  // The settings straight out of reset: 512x512 into 640x640, so there is no border inside.
  task automatic test_reset_settings();
    query_pixel(0, 0);
    query_pixel(639, 639);
    query_pixel(320, 1);
    query_pixel(640, 0);
    query_pixel(1023, 1023);
    // Both loads are outside the store and dropped; in-store loads beyond the image are kept.
    send_request(KIND_LOAD, 1023, 3, '1);
    send_request(KIND_LOAD, 3, 700, '1);
  endtask

  task automatic test_extremes();
    set_pad(255, 0, 170);
    // Wide and flat source: the height of the image rounds to nothing, so it is all border.
    set_geometry(512, 1, 1, 1);
    query_pixel(0, 0);
    // Out-of-range sizes saturate: width 0 acts as 1, 1023 as 512, 2047 as 1024.
    set_geometry(0, 1023, 2047, 2047);
    query_pixel(512, 0);
    query_pixel(511, 1023);
    query_pixel(512, 1023);
    query_pixel(0, 512);
    // A one-pixel source stretched over the whole output.
    set_geometry(1, 1, 1024, 1024);
    query_pixel(0, 0);
    query_pixel(1023, 1023);
    // Tall source: border columns to the left and right of the image.
    set_geometry(2, 8, 40, 20);
    for (int c = 0; c < 40; c += 7) query_pixel(c, 10);
    query_pixel(17, 19);
    query_pixel(22, 0);
    // A write to an unused index must leave every register alone.
    wait_idle();
    write_reg(REG_UNUSED, 11'h7ff);
    query_pixel(20, 5);
  endtask

  // The receiver refuses results for a long stretch while queries keep coming, so the
  // pipeline fills and the input stalls; then the sender waits for every result.
  task automatic test_backpressure();
    set_geometry(16, 12, 64, 48);
    for (int r = 0; r < 12; r++)
      for (int c = 0; c < 16; c++) send_request(KIND_LOAD, c, r, PIX_W'($urandom));
    hold_requests++;
    send_steady = 1'b1;
    for (int i = 0; i < 80; i++) query_pixel($urandom_range(63), $urandom_range(47));
    send_steady = 1'b0;
    wait_idle();
  endtask

  // Random phases: fresh settings, then a stream that is mostly queries inside the output with
  // loads of source pixels, and some noise: loads outside the store and queries anywhere.
  task automatic test_random_phases();
    int unsigned sw, sh, dw, dh, pick;
    for (int p = 0; p < 12; p++) begin
      sw = ($urandom_range(9) == 0) ? 512 : $urandom_range(24, 1);
      sh = ($urandom_range(9) == 0) ? 512 : $urandom_range(24, 1);
      dw = ($urandom_range(9) == 0) ? 1024 : $urandom_range(80, 1);
      dh = ($urandom_range(9) == 0) ? 1024 : $urandom_range(80, 1);
      set_geometry(sw, sh, dw, dh);
      set_pad($urandom_range(255), $urandom_range(255), $urandom_range(255));
      send_steady = (p == 4);
      recv_steady = (p == 4);
      for (int i = 0; i < 120; i++) begin
        pick = $urandom_range(99);
        if (pick < 65)
          query_pixel($urandom_range(dw), $urandom_range(dh));
        else if (pick < 88)
          send_request(KIND_LOAD, $urandom_range(sw - 1), $urandom_range(sh - 1),
                       PIX_W'($urandom));
        else if (pick < 94)
          send_request(KIND_LOAD, $urandom_range(1023), $urandom_range(1023), PIX_W'($urandom));
        else
          query_pixel($urandom_range(1023), $urandom_range(1023));
      end
      send_steady = 1'b0;
      recv_steady = 1'b0;
    end
  endtask

  // Receiver: random refusals, and the long hold-off counted down here.
  always @(negedge clk) begin
    if (hold_taken != hold_requests) begin
      hold_taken = hold_requests;
      hold_off = HOLD_CYCLES;
    end
    if (hold_off > 0) begin
      out_px.ready <= 1'b0;
      hold_off = hold_off - 1;
    end else begin
      out_px.ready <= recv_steady || ($urandom_range(99) >= 11);
    end
  end

  // Each result is compared with the oldest expected pixel.
  always @(posedge clk) begin
    if (rst_n && out_px.valid && out_px.ready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected result ch0=%0d ch1=%0d ch2=%0d border=%0b", $time,
                 out_px.out_ch0, out_px.out_ch1, out_px.out_ch2, out_px.in_border);
        errors++;
      end else begin
        pixel_t exp_px;
        exp_px = pending_pixels.pop_front();
        if (out_px.out_ch0 !== exp_px.ch0 || out_px.out_ch1 !== exp_px.ch1 ||
            out_px.out_ch2 !== exp_px.ch2 || out_px.in_border !== exp_px.border) begin
          $display("%0t: expected ch0=%0d ch1=%0d ch2=%0d border=%0b, got %0d %0d %0d %0b",
                   $time, exp_px.ch0, exp_px.ch1, exp_px.ch2, exp_px.border,
                   out_px.out_ch0, out_px.out_ch1, out_px.out_ch2, out_px.in_border);
          errors++;
        end
      end
    end
  end

  initial begin
    in_px.valid = 1'b0;
    in_px.kind = KIND_LOAD;
    in_px.col = '0;
    in_px.row = '0;
    in_px.in_ch0 = '0;
    in_px.in_ch1 = '0;
    in_px.in_ch2 = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_settings();
    test_extremes();
    test_backpressure();
    test_random_phases();
    in_px.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Far beyond the slowest correct run, geometry recalculations included.
  initial begin
    #30000000;
    $display("tb: failure");
    $finish;
  end

endmodule
